// File: rtl/core/scpq14_pkg.sv
package scpq14_pkg;

    // Sign-magnitude word: bit 15 sign, bits 14..0 magnitude, 14 fraction bits.
    typedef logic [15:0] sm_t;

    localparam int unsigned SmWidth  = 16;
    localparam int unsigned MagWidth = 15;
    localparam int unsigned FracBits = 14;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_ONE         = 3'd0;
    localparam logic [2:0] REG_COEF_SIN_THIRD   = 3'd1;
    localparam logic [2:0] REG_COEF_SIN_FIFTH   = 3'd2;
    localparam logic [2:0] REG_COEF_SIN_SEVENTH = 3'd3;
    localparam logic [2:0] REG_COEF_COS_SECOND  = 3'd4;
    localparam logic [2:0] REG_COEF_COS_FOURTH  = 3'd5;
    localparam logic [2:0] REG_COEF_COS_SIXTH   = 3'd6;

    // Coefficient values after reset.
    localparam sm_t RST_COEF_ONE         = 16'h4000;
    localparam sm_t RST_COEF_SIN_THIRD   = 16'h8AAB;
    localparam sm_t RST_COEF_SIN_FIFTH   = 16'h0089;
    localparam sm_t RST_COEF_SIN_SEVENTH = 16'h8003;
    localparam sm_t RST_COEF_COS_SECOND  = 16'hA000;
    localparam sm_t RST_COEF_COS_FOURTH  = 16'h02AB;
    localparam sm_t RST_COEF_COS_SIXTH   = 16'h8017;

    // Magnitude product shifted right by the fraction width, wrapped to 15 bits.
    function automatic sm_t sm_mul(input sm_t a, input sm_t b);
        logic [2*MagWidth-1:0] prod;
        prod = a[MagWidth-1:0] * b[MagWidth-1:0];
        return {a[SmWidth-1] ^ b[SmWidth-1], prod[FracBits+MagWidth-1:FracBits]};
    endfunction

    // Sign-magnitude add; a tie of opposite signs takes the sign of b.
    function automatic sm_t sm_add(input sm_t a, input sm_t b);
        logic [MagWidth:0] sum;
        logic              sign;
        if (a[SmWidth-1] == b[SmWidth-1]) begin
            sum  = {1'b0, a[MagWidth-1:0]} + {1'b0, b[MagWidth-1:0]};
            sign = a[SmWidth-1];
        end else if (a[MagWidth-1:0] > b[MagWidth-1:0]) begin
            sum  = {1'b0, a[MagWidth-1:0]} - {1'b0, b[MagWidth-1:0]};
            sign = a[SmWidth-1];
        end else begin
            sum  = {1'b0, b[MagWidth-1:0]} - {1'b0, a[MagWidth-1:0]};
            sign = b[SmWidth-1];
        end
        return {sign, sum[MagWidth-1:0]};
    endfunction

endpackage

// File: rtl/core/sine_cosine_polynomial_q14_core.sv
// Channel  | Direction | Payload
// s_       | in        | tdata[15:0] angle
// m_       | out       | tdata[15:0] sine_value, tdata[31:16] cosine_value
// cfg_     | in        | cfg_index selects coefficient 0..6, cfg_wdata[15:0]
//
// Five register stages: the first squares the angle, the next three multiply in
// both the sine and cosine chains, and the last multiplies only the sine. One
// item is accepted every cycle while the output is not stalled.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// default coefficients.
module sine_cosine_polynomial_q14_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  scpq14_pkg::sm_t         s_tdata,     // [15:0] angle
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,     // [15:0] sine_value, [31:16] cosine_value
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_wdata
);
    import scpq14_pkg::*;

    localparam int unsigned NumStages = 5;

    sm_t coef_one_reg, coef_s3_reg, coef_s5_reg, coef_s7_reg;
    sm_t coef_c2_reg, coef_c4_reg, coef_c6_reg;

    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] rdy;

    // Stage payloads.
    sm_t x1_reg, xsq1_reg;
    sm_t x2_reg, xsq2_reg, sin2_reg, cos2_reg;
    sm_t x3_reg, xsq3_reg, sin3_reg, cos3_reg;
    sm_t x4_reg, sin4_reg, cos4_reg;
    sm_t sin5_reg, cos5_reg;

    sm_t xsq1_next, sin2_next, cos2_next, sin3_next, cos3_next;
    sm_t sin4_next, cos4_next, sin5_next, cos5_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_one_reg <= RST_COEF_ONE;
            coef_s3_reg  <= RST_COEF_SIN_THIRD;
            coef_s5_reg  <= RST_COEF_SIN_FIFTH;
            coef_s7_reg  <= RST_COEF_SIN_SEVENTH;
            coef_c2_reg  <= RST_COEF_COS_SECOND;
            coef_c4_reg  <= RST_COEF_COS_FOURTH;
            coef_c6_reg  <= RST_COEF_COS_SIXTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEF_ONE:         coef_one_reg <= cfg_wdata;
                REG_COEF_SIN_THIRD:   coef_s3_reg  <= cfg_wdata;
                REG_COEF_SIN_FIFTH:   coef_s5_reg  <= cfg_wdata;
                REG_COEF_SIN_SEVENTH: coef_s7_reg  <= cfg_wdata;
                REG_COEF_COS_SECOND:  coef_c2_reg  <= cfg_wdata;
                REG_COEF_COS_FOURTH:  coef_c4_reg  <= cfg_wdata;
                REG_COEF_COS_SIXTH:   coef_c6_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage can load when it is empty or its item moves on this cycle.
    always_comb begin
        rdy[NumStages-1] = !valid_reg[NumStages-1] || m_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_comb begin
        xsq1_next = sm_mul(s_tdata, s_tdata);
        sin2_next = sm_mul(coef_s7_reg, xsq1_reg);
        cos2_next = sm_mul(coef_c6_reg, xsq1_reg);
        sin3_next = sm_mul(sm_add(sin2_reg, coef_s5_reg), xsq2_reg);
        cos3_next = sm_mul(sm_add(cos2_reg, coef_c4_reg), xsq2_reg);
        sin4_next = sm_mul(sm_add(sin3_reg, coef_s3_reg), xsq3_reg);
        cos4_next = sm_mul(sm_add(cos3_reg, coef_c2_reg), xsq3_reg);
        sin5_next = sm_mul(sm_add(sin4_reg, coef_one_reg), x4_reg);
        cos5_next = sm_add(cos4_reg, coef_one_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NumStages; k++) begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_tvalid) begin
            x1_reg   <= s_tdata;
            xsq1_reg <= xsq1_next;
        end
        if (rdy[1] && valid_reg[0]) begin
            x2_reg   <= x1_reg;
            xsq2_reg <= xsq1_reg;
            sin2_reg <= sin2_next;
            cos2_reg <= cos2_next;
        end
        if (rdy[2] && valid_reg[1]) begin
            x3_reg   <= x2_reg;
            xsq3_reg <= xsq2_reg;
            sin3_reg <= sin3_next;
            cos3_reg <= cos3_next;
        end
        if (rdy[3] && valid_reg[2]) begin
            x4_reg   <= x3_reg;
            sin4_reg <= sin4_next;
            cos4_reg <= cos4_next;
        end
        if (rdy[4] && valid_reg[3]) begin
            sin5_reg <= sin5_next;
            cos5_reg <= cos5_next;
        end
    end

    assign m_tvalid = valid_reg[NumStages-1];
    assign m_tdata  = {cos5_reg, sin5_reg};

    // An accepted item always lands in the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    // Input back-pressure only happens with every stage full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &valid_reg)
        else $error("input stalled while a stage is empty");

    // A held item in a middle stage is not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[2] && !rdy[3] |=> valid_reg[2] && $stable(sin3_reg) && $stable(cos3_reg))
        else $error("stalled stage item lost or changed");

    // With the output taken, the stage before always drains into it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] && m_tready |=> m_tvalid)
        else $error("item did not advance to output stage");

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scpq14_pkg::*;

    localparam int unsigned PIPE_LATENCY  = 5;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned RANDOM_PHASES = 3;
    localparam logic [2:0]  REG_UNUSED    = 3'd7;

    typedef struct packed {
        sm_t cosine;
        sm_t sine;
    } sincos_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    sm_t         s_tdata;     // [15:0] angle
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [15:0] sine_value, [31:16] cosine_value
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    sine_cosine_polynomial_q14_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Coefficient shadow, indexed by register index.
    sm_t     coef_regs [0:6];
    sincos_t expected_sincos [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned angles_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned error_count;
    int unsigned cycle_count;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic sm_t sm_product(input sm_t a, input sm_t b);
        logic [29:0] mag_prod;
        logic [29:0] scaled;
        mag_prod = {15'd0, a[14:0]} * {15'd0, b[14:0]};
        scaled   = mag_prod >> 14;
        return {a[15] ^ b[15], scaled[14:0]};
    endfunction

    // Opposite signs of equal magnitude give zero with the sign of b.
    function automatic sm_t sm_sum(input sm_t a, input sm_t b);
        logic [15:0] mag;
        logic        sign;
        if (a[15] == b[15]) begin
            mag  = {1'b0, a[14:0]} + {1'b0, b[14:0]};
            sign = a[15];
        end else if (a[14:0] > b[14:0]) begin
            mag  = {1'b0, a[14:0]} - {1'b0, b[14:0]};
            sign = a[15];
        end else begin
            mag  = {1'b0, b[14:0]} - {1'b0, a[14:0]};
            sign = b[15];
        end
        return {sign, mag[14:0]};
    endfunction

    function automatic sincos_t angle_to_sincos(input sm_t x);
        sm_t     x2;
        sm_t     s;
        sm_t     c;
        sincos_t r;
        x2 = sm_product(x, x);
        s = sm_sum(sm_product(coef_regs[REG_COEF_SIN_SEVENTH], x2),
                   coef_regs[REG_COEF_SIN_FIFTH]);
        s = sm_sum(sm_product(s, x2), coef_regs[REG_COEF_SIN_THIRD]);
        s = sm_sum(sm_product(s, x2), coef_regs[REG_COEF_ONE]);
        s = sm_product(s, x);
        c = sm_sum(sm_product(coef_regs[REG_COEF_COS_SIXTH], x2),
                   coef_regs[REG_COEF_COS_FOURTH]);
        c = sm_sum(sm_product(c, x2), coef_regs[REG_COEF_COS_SECOND]);
        c = sm_sum(sm_product(c, x2), coef_regs[REG_COEF_ONE]);
        r.sine   = s;
        r.cosine = c;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high.
    task automatic send_angle(input sm_t angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = angle;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_sincos.push_back(angle_to_sincos(angle));
        angles_sent++;
        @(negedge aclk);
    endtask

    // Lets every expected item arrive and the pipeline run empty.
    task automatic settle_pipeline();
        s_tvalid = 1'b0;
        while (expected_sincos.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 3) @(negedge aclk);
    endtask

    task automatic write_coef(input logic [2:0] idx, input sm_t value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        if (idx <= REG_COEF_COS_SIXTH) coef_regs[idx] = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Element i of vals goes to register index i.
    task automatic load_coefs(input logic [6:0][15:0] vals);
        for (int i = 0; i <= int'(REG_COEF_COS_SIXTH); i++) write_coef(3'(i), vals[i]);
        settings_used++;
    endtask

    function automatic sm_t pick_angle();
        sm_t a;
        case ($urandom_range(3))
            0: a = 16'($urandom);
            1: a = {1'($urandom), 15'($urandom_range(25736))};
            2: a = {1'($urandom), 15'($urandom_range(255))};
            default: a = {1'($urandom), 15'($urandom_range(16'h7FFF, 16'h7FF0))};
        endcase
        return a;
    endfunction

    function automatic sm_t pick_coef();
        if ($urandom_range(3) == 0) return {1'($urandom), 15'($urandom_range(1023))};
        return 16'($urandom);
    endfunction

    always @(posedge aclk) begin
        sincos_t want;
        sincos_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_sincos.size() == 0) begin
                $display("%0t: unexpected result, actual sine %h cosine %h",
                         $time, got.sine, got.cosine);
                error_count++;
            end else begin
                want = expected_sincos.pop_front();
                results_checked++;
                if (got.sine !== want.sine) begin
                    $display("%0t: sine mismatch, expected %h actual %h",
                             $time, want.sine, got.sine);
                    error_count++;
                end
                if (got.cosine !== want.cosine) begin
                    $display("%0t: cosine mismatch, expected %h actual %h",
                             $time, want.cosine, got.cosine);
                    error_count++;
                end
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_sincos.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic test_default_coefficients();
        sm_t angles [10];
        angles = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h4000,
                   16'hC000, 16'h6488, 16'hE488, 16'h0001, 16'h8001};
        foreach (angles[i]) send_angle(angles[i]);
        settle_pipeline();
    endtask

    // Zero magnitudes of mixed sign make most adds in both chains a tie.
    task automatic test_sign_ties();
        load_coefs({16'h0000, 16'h8000, 16'h0000, 16'h8000,
                    16'h8000, 16'h0000, 16'h8000});
        send_angle(16'h0000);
        send_angle(16'h8000);
        settle_pipeline();
    endtask

    // Full-scale magnitudes make products and sums wrap.
    task automatic test_magnitude_wrap();
        sm_t fill [2];
        fill = '{16'h7FFF, 16'hFFFF};
        foreach (fill[i]) begin
            load_coefs({7{fill[i]}});
            send_angle(16'h7FFF);
            send_angle(16'hFFFF);
            send_angle(16'h6000);
            settle_pipeline();
        end
    endtask

    // A write beyond the last register must leave every coefficient alone.
    task automatic test_unused_index();
        load_coefs({RST_COEF_COS_SIXTH, RST_COEF_COS_FOURTH, RST_COEF_COS_SECOND,
                    RST_COEF_SIN_SEVENTH, RST_COEF_SIN_FIFTH, RST_COEF_SIN_THIRD,
                    RST_COEF_ONE});
        write_coef(REG_UNUSED, 16'hFFFF);
        write_coef(REG_UNUSED, 16'h0000);
        send_angle(16'h2000);
        send_angle(16'hA000);
        send_angle(16'h5555);
        settle_pipeline();
    endtask

    task automatic test_random_angles();
        int unsigned idle_send [RANDOM_PHASES];
        int unsigned idle_recv [RANDOM_PHASES];
        logic [6:0][15:0] vals;
        idle_send = '{10, 82, 0};
        idle_recv = '{82, 10, 0};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            for (int i = 0; i < 7; i++) vals[i] = pick_coef();
            load_coefs(vals);
            if ($urandom_range(1)) write_coef(REG_UNUSED, 16'($urandom));
            repeat (RANDOM_ITEMS / RANDOM_PHASES) send_angle(pick_angle());
            settle_pipeline();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 10;
        recv_stall_pct = 82;
        coef_regs[REG_COEF_ONE]         = RST_COEF_ONE;
        coef_regs[REG_COEF_SIN_THIRD]   = RST_COEF_SIN_THIRD;
        coef_regs[REG_COEF_SIN_FIFTH]   = RST_COEF_SIN_FIFTH;
        coef_regs[REG_COEF_SIN_SEVENTH] = RST_COEF_SIN_SEVENTH;
        coef_regs[REG_COEF_COS_SECOND]  = RST_COEF_COS_SECOND;
        coef_regs[REG_COEF_COS_FOURTH]  = RST_COEF_COS_FOURTH;
        coef_regs[REG_COEF_COS_SIXTH]   = RST_COEF_COS_SIXTH;
        settings_used = 1;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_default_coefficients();
        test_sign_ties();
        test_magnitude_wrap();
        test_unused_index();
        test_random_angles();

        $display("Sent %0d angles and checked %0d sine/cosine results", angles_sent,
                 results_checked);
        $display("over %0d coefficient settings and three back-pressure mixes.",
                 settings_used);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/scpq14_pkg.sv
rtl/core/sine_cosine_polynomial_q14_core.sv
test/tb_top.sv
